@@ design/tension_motor_mode_controller_top_macros.svh @@
// assertion macros for the tension motor mode controller
// used by the top level only, clocked on clk, held off during rst
`ifndef TENSION_MOTOR_MODE_CONTROLLER_TOP_MACROS_SVH
`define TENSION_MOTOR_MODE_CONTROLLER_TOP_MACROS_SVH

// condition that holds on every clock edge
`define TMMC_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("tmmc invariant violated");

// condition that implies a consequence on the following clock edge
`define TMMC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tmmc sequence violated");

`endif

@@ design/tmmc_pkg.sv @@
// shared types, codes and constants of the tension motor mode controller
// no dependencies
package tmmc_pkg;

  localparam logic [2:0] CMD_SAMPLE    = 3'd0;
  localparam logic [2:0] CMD_SECOND    = 3'd1;
  localparam logic [2:0] CMD_KEY       = 3'd2;
  localparam logic [2:0] CMD_GOOD      = 3'd3;
  localparam logic [2:0] CMD_BAD       = 3'd4;

  localparam logic [1:0] KEY_IDLE      = 2'd0;
  localparam logic [1:0] KEY_ONE       = 2'd1;
  localparam logic [1:0] KEY_TWO       = 2'd2;
  localparam logic [1:0] KEY_THREE     = 2'd3;

  localparam logic [2:0] MODE_STOP     = 3'd0;
  localparam logic [2:0] MODE_RUN      = 3'd1;
  localparam logic [2:0] MODE_HOLD     = 3'd2;
  localparam logic [2:0] MODE_HOME     = 3'd3;
  localparam logic [2:0] MODE_FWD      = 3'd4;
  localparam logic [2:0] MODE_RESUME   = 3'd5;
  localparam logic [2:0] MODE_OVC      = 3'd6;

  localparam logic [1:0] DIR_STOP      = 2'd0;
  localparam logic [1:0] DIR_FWD       = 2'd1;
  localparam logic [1:0] DIR_REV       = 2'd2;

  localparam logic [2:0] REG_TARGET    = 3'd0;
  localparam logic [2:0] REG_TOLERANCE = 3'd1;
  localparam logic [2:0] REG_MAX       = 3'd2;
  localparam logic [2:0] REG_ZERO      = 3'd3;
  localparam logic [2:0] REG_CURRENT   = 3'd4;

  localparam logic [9:0] SPEED_BAND_TOP  = 10'd850;
  localparam logic [9:0] SPEED_BAND_HIGH = 10'd800;
  localparam logic [9:0] SPEED_BAND_MID  = 10'd750;
  localparam logic [9:0] SPEED_BAND_LOW  = 10'd500;

  localparam logic [24:0] ERR_TOP      = 25'd1000;
  localparam logic [24:0] ERR_HIGH     = 25'd800;
  localparam logic [24:0] ERR_MID      = 25'd600;
  localparam logic [24:0] HOME_WINDOW  = 25'd300;

  localparam logic [7:0] FWD_SECONDS   = 8'd45;
  localparam logic [7:0] HOME_SECONDS  = 8'd30;
  localparam logic [7:0] SECONDS_SAT   = 8'd255;
  localparam logic [6:0] OVC_RECOVER   = 7'd5;
  localparam logic [6:0] OVC_GIVE_UP   = 7'd100;
  localparam logic [3:0] SILENCE_LIMIT = 4'd10;
  localparam logic [4:0] BAD_LIMIT     = 5'd20;

  typedef struct packed {
    logic        [2:0]  cmd;
    logic        [1:0]  key_code;
    logic signed [23:0] load_grams;
    logic        [11:0] current_code;
    logic               device_on;
    logic               run_enable;
  } in_item_t;

  typedef struct packed {
    logic [1:0] motor_direction;
    logic [9:0] drive_rate;
    logic [2:0] mode;
    logic       system_reset;
  } out_item_t;

  typedef struct packed {
    logic signed [23:0] target_weight;
    logic        [22:0] tolerance;
    logic signed [23:0] weight_ceiling;
    logic signed [23:0] zero_weight;
    logic        [11:0] current_limit;
  } cfg_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [1:0] direction;
    logic [9:0] speed;
    logic       calibrate_pending;
    logic       forward_armed;
    logic [7:0] forward_seconds;
    logic       home_armed;
    logic [7:0] home_seconds;
    logic       overcurrent_active;
    logic [6:0] overcurrent_seconds;
    logic [3:0] link_silence;
    logic [4:0] bad_frame_count;
  } state_t;

  localparam state_t STATE_RESET = '{
    mode:                MODE_STOP,
    direction:           DIR_STOP,
    speed:               10'd0,
    calibrate_pending:   1'b0,
    forward_armed:       1'b0,
    forward_seconds:     8'd0,
    home_armed:          1'b0,
    home_seconds:        8'd0,
    overcurrent_active:  1'b0,
    overcurrent_seconds: 7'd0,
    link_silence:        4'd0,
    bad_frame_count:     5'd0
  };

  localparam cfg_t CFG_RESET = '{
    target_weight:  24'sd0,
    tolerance:      23'd200,
    weight_ceiling: 24'sd8388607,
    zero_weight:    24'sd0,
    current_limit:  12'd4095
  };

endpackage

@@ design/tmmc_cfg_regs.sv @@
// configuration register file of the tension motor mode controller
// depends on tmmc_pkg
module tmmc_cfg_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  output tmmc_pkg::cfg_t     cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= tmmc_pkg::CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tmmc_pkg::REG_TARGET:    cfg.target_weight  <= cfg_data;
        tmmc_pkg::REG_TOLERANCE: cfg.tolerance      <= cfg_data[22:0];
        tmmc_pkg::REG_MAX:       cfg.weight_ceiling <= cfg_data;
        tmmc_pkg::REG_ZERO:      cfg.zero_weight    <= cfg_data;
        tmmc_pkg::REG_CURRENT:   cfg.current_limit  <= cfg_data[11:0];
        default: begin
        end
      endcase
    end
  end

endmodule

@@ design/tmmc_step.sv @@
// single-pass next-state and result logic for one item
// depends on tmmc_pkg
module tmmc_step (
  input  tmmc_pkg::state_t    st,
  input  tmmc_pkg::cfg_t      cfg,
  input  tmmc_pkg::in_item_t  item,
  output tmmc_pkg::state_t    st_next,
  output tmmc_pkg::out_item_t res
);

  logic signed [24:0] err;
  logic        [24:0] diff;
  logic        [9:0]  band;
  logic               enabled;
  logic               sys_reset;
  tmmc_pkg::state_t   nx;

  assign err     = {item.load_grams[23], item.load_grams}
                 - {cfg.target_weight[23], cfg.target_weight};
  assign diff    = err[24] ? 25'(-err) : 25'(err);
  assign enabled = item.device_on & item.run_enable;

  always_comb begin
    if (diff > tmmc_pkg::ERR_TOP) begin
      band = tmmc_pkg::SPEED_BAND_TOP;
    end else if (diff > tmmc_pkg::ERR_HIGH) begin
      band = tmmc_pkg::SPEED_BAND_HIGH;
    end else if (diff > tmmc_pkg::ERR_MID) begin
      band = tmmc_pkg::SPEED_BAND_MID;
    end else begin
      band = tmmc_pkg::SPEED_BAND_LOW;
    end
  end

  always_comb begin
    nx        = st;
    sys_reset = 1'b0;
    unique case (item.cmd)
      tmmc_pkg::CMD_SAMPLE: begin
        // overcurrent trip while regulating
        if (item.current_code >= cfg.current_limit && nx.mode == tmmc_pkg::MODE_RUN) begin
          if (nx.direction == tmmc_pkg::DIR_REV) begin
            nx.direction = tmmc_pkg::DIR_FWD;
          end else if (nx.direction == tmmc_pkg::DIR_FWD) begin
            nx.direction = tmmc_pkg::DIR_REV;
          end
          nx.speed               = tmmc_pkg::SPEED_BAND_TOP;
          nx.mode                = tmmc_pkg::MODE_OVC;
          nx.overcurrent_active  = 1'b1;
          nx.overcurrent_seconds = '0;
        end
        unique case (nx.mode)
          tmmc_pkg::MODE_STOP: begin
            if (enabled) nx.mode = tmmc_pkg::MODE_RUN;
          end
          tmmc_pkg::MODE_RUN: begin
            nx.calibrate_pending = 1'b0;
            if (!enabled) begin
              nx.mode      = tmmc_pkg::MODE_STOP;
              nx.direction = tmmc_pkg::DIR_STOP;
            end else if (item.load_grams >= cfg.weight_ceiling
                         || diff <= {2'b00, cfg.tolerance}
                         || item.load_grams <= cfg.zero_weight) begin
              nx.direction = tmmc_pkg::DIR_STOP;
            end else if (item.load_grams > cfg.target_weight) begin
              nx.speed     = band;
              nx.direction = tmmc_pkg::DIR_REV;
            end else if (item.load_grams < cfg.target_weight) begin
              nx.speed     = band;
              nx.direction = tmmc_pkg::DIR_FWD;
            end
          end
          tmmc_pkg::MODE_HOLD: begin
            nx.speed     = tmmc_pkg::SPEED_BAND_TOP;
            nx.direction = tmmc_pkg::DIR_REV;
          end
          tmmc_pkg::MODE_HOME: begin
            nx.speed     = tmmc_pkg::SPEED_BAND_TOP;
            nx.direction = tmmc_pkg::DIR_REV;
            if (enabled && item.load_grams < cfg.weight_ceiling
                && (diff <= tmmc_pkg::HOME_WINDOW || item.load_grams <= cfg.zero_weight)) begin
              nx.direction    = tmmc_pkg::DIR_STOP;
              nx.home_armed   = 1'b0;
              nx.home_seconds = '0;
              nx.mode         = tmmc_pkg::MODE_RUN;
            end else if (!nx.home_armed) begin
              nx.home_armed   = 1'b1;
              nx.home_seconds = '0;
            end else if (nx.home_seconds >= tmmc_pkg::HOME_SECONDS) begin
              nx.direction  = tmmc_pkg::DIR_STOP;
              nx.home_armed = 1'b0;
              nx.mode       = tmmc_pkg::MODE_STOP;
            end
          end
          tmmc_pkg::MODE_FWD: begin
            nx.speed     = tmmc_pkg::SPEED_BAND_TOP;
            nx.direction = tmmc_pkg::DIR_FWD;
            if (!nx.forward_armed) begin
              nx.forward_armed   = 1'b1;
              nx.forward_seconds = '0;
            end else if (nx.forward_seconds >= tmmc_pkg::FWD_SECONDS) begin
              nx.calibrate_pending = 1'b0;
              nx.mode              = tmmc_pkg::MODE_STOP;
              nx.direction         = tmmc_pkg::DIR_STOP;
            end
          end
          tmmc_pkg::MODE_RESUME: begin
            if (enabled && item.load_grams <= cfg.target_weight) begin
              nx.mode = tmmc_pkg::MODE_RUN;
            end else begin
              nx.direction = tmmc_pkg::DIR_STOP;
            end
          end
          tmmc_pkg::MODE_OVC: begin
            if (nx.overcurrent_seconds >= tmmc_pkg::OVC_RECOVER) begin
              nx.overcurrent_seconds = '0;
              nx.overcurrent_active  = 1'b0;
              nx.direction           = tmmc_pkg::DIR_STOP;
              nx.mode                = tmmc_pkg::MODE_RUN;
            end
          end
          default: begin
          end
        endcase
      end
      tmmc_pkg::CMD_SECOND: begin
        if (nx.forward_armed) begin
          if (nx.forward_seconds < tmmc_pkg::SECONDS_SAT) begin
            nx.forward_seconds = nx.forward_seconds + 8'd1;
          end
        end else begin
          nx.forward_seconds = '0;
        end
        if (nx.home_armed) begin
          if (nx.home_seconds < tmmc_pkg::SECONDS_SAT) begin
            nx.home_seconds = nx.home_seconds + 8'd1;
          end
        end else begin
          nx.home_seconds = '0;
        end
        nx.link_silence = nx.link_silence + 4'd1;
        if (nx.link_silence >= tmmc_pkg::SILENCE_LIMIT) begin
          sys_reset = 1'b1;
        end else if (nx.overcurrent_active) begin
          nx.overcurrent_seconds = nx.overcurrent_seconds + 7'd1;
          if (nx.overcurrent_seconds >= tmmc_pkg::OVC_GIVE_UP) begin
            nx.overcurrent_seconds = '0;
            nx.overcurrent_active  = 1'b0;
            nx.direction           = tmmc_pkg::DIR_STOP;
            nx.mode                = tmmc_pkg::MODE_STOP;
          end
        end
      end
      tmmc_pkg::CMD_KEY: begin
        unique case (item.key_code)
          tmmc_pkg::KEY_IDLE: begin
          end
          tmmc_pkg::KEY_ONE: begin
            if (nx.calibrate_pending) begin
              nx.forward_armed = 1'b0;
              nx.mode          = tmmc_pkg::MODE_FWD;
            end else begin
              nx.mode = tmmc_pkg::MODE_RESUME;
            end
          end
          tmmc_pkg::KEY_TWO: begin
            nx.home_armed = 1'b0;
            nx.mode       = tmmc_pkg::MODE_HOME;
          end
          tmmc_pkg::KEY_THREE: begin
            nx.mode              = tmmc_pkg::MODE_HOLD;
            nx.calibrate_pending = 1'b1;
          end
          default: begin
          end
        endcase
      end
      tmmc_pkg::CMD_GOOD: begin
        nx.link_silence = '0;
      end
      tmmc_pkg::CMD_BAD: begin
        nx.bad_frame_count = nx.bad_frame_count + 5'd1;
        if (nx.bad_frame_count >= tmmc_pkg::BAD_LIMIT) sys_reset = 1'b1;
      end
      default: begin
      end
    endcase
    if (sys_reset) nx = tmmc_pkg::STATE_RESET;
  end

  assign st_next             = nx;
  assign res.motor_direction = nx.direction;
  assign res.drive_rate      = nx.speed;
  assign res.mode            = nx.mode;
  assign res.system_reset    = sys_reset;

endmodule

@@ design/tension_motor_mode_controller_top.sv @@
// top level of the tension motor mode controller
// depends on tmmc_pkg, tmmc_cfg_regs, tmmc_step and the assertion macro header
`include "tension_motor_mode_controller_top_macros.svh"

// Accepts one item per clock unless in_stall is high, and returns one result
// per item. The item waits in the input register; its result is registered in
// the result register once the output is not stalled. Each item passes once
// through the mode and speed logic between the two registers, and that logic
// also updates the controller state, so throughput is one item per cycle while
// the output does not stall. Configuration writes are always ready and take
// effect on the next cycle; write them only while no item is in flight.
module tension_motor_mode_controller_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  tmmc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tmmc_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [23:0]         cfg_data
);

  tmmc_pkg::cfg_t      cfg;
  tmmc_pkg::state_t    st;
  tmmc_pkg::state_t    st_next;
  tmmc_pkg::in_item_t  s1_item;
  tmmc_pkg::out_item_t res;
  logic                s1_valid;
  logic                fire;

  tmmc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tmmc_step u_step (
    .st      (st),
    .cfg     (cfg),
    .item    (s1_item),
    .st_next (st_next),
    .res     (res)
  );

  assign fire     = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      st        <= tmmc_pkg::STATE_RESET;
    end else begin
      if (in_valid && !in_stall) begin
        s1_valid <= 1'b1;
      end else if (fire) begin
        s1_valid <= 1'b0;
      end
      if (fire) begin
        out_valid <= 1'b1;
        st        <= st_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) s1_item <= in_data;
    if (fire) out_data <= res;
  end

  `TMMC_ASSERT_ALWAYS(a_reset_result_clear,
    !(out_valid && out_data.system_reset)
    || (out_data.mode == tmmc_pkg::MODE_STOP
        && out_data.motor_direction == tmmc_pkg::DIR_STOP
        && out_data.drive_rate == 10'd0))
  `TMMC_ASSERT_ALWAYS(a_ovc_mode_active,
    st.mode != tmmc_pkg::MODE_OVC || st.overcurrent_active)
  `TMMC_ASSERT_ALWAYS(a_link_counters_bounded,
    st.link_silence < tmmc_pkg::SILENCE_LIMIT && st.bad_frame_count < tmmc_pkg::BAD_LIMIT)
  `TMMC_ASSERT_NEXT(a_fire_gives_result, fire, out_valid)

endmodule
